// ----- src/rhh_pkg.sv -----
// ----------------------------------------------------------------------------
// rhh_pkg: shared types and constants of the Robin Hood hash table
// Bucket count, key width, operation and status codes, control bundles.
// ----------------------------------------------------------------------------
package rhh_pkg;

  localparam int NUM_BUCKETS = 64;
  localparam int KEY_BITS    = 32;
  localparam int IDX_W       = $clog2(NUM_BUCKETS);
  localparam int CNT_W       = $clog2(NUM_BUCKETS + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture item, start at home bucket
    logic rewind;     // restart probe at home bucket, distance zero
    logic rd;         // read bucket at current index
    logic step;       // advance index and distance
    logic to_found;   // continue from the found position: previous at it, index one past it
    logic put;        // write carried key/dist into current bucket (swap)
    logic fill;       // write carried key into empty bucket, set valid
    logic shift;      // copy next bucket (read data) into previous
    logic clear;      // invalidate previous bucket (end of shift)
    logic occ_inc;
    logic occ_dec;
  } rhh_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic valid;      // current bucket valid
    logic key_eq;     // resident key matches
    logic dist_gt;    // carried distance exceeds resident's
    logic dist_zero;  // resident distance is zero
    logic last;       // whole table visited
    logic full;       // occupancy at capacity
  } rhh_sts_t;

endpackage

// ----- src/rhh_datapath.sv -----
// ----------------------------------------------------------------------------
// rhh_datapath: bucket memory, probe index and carried entry
// Key/distance memory with registered read, valid bits and occupancy count.
// ----------------------------------------------------------------------------
module rhh_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  rhh_pkg::rhh_cmd_t   cmd,
  input  logic [31:0]         in_key,
  input  logic [31:0]         in_hash,
  output rhh_pkg::rhh_sts_t   sts
);
  import rhh_pkg::*;

  key_t   mem_key [NUM_BUCKETS];
  idx_t   mem_dist[NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] valid_r;

  key_t   rd_key_r;
  idx_t   rd_dist_r;
  logic   rd_valid_r;

  key_t   car_key_r;
  idx_t   car_dist_r;
  idx_t   idx_r;
  idx_t   home_r;
  idx_t   prev_r;
  idx_t   found_r;
  cnt_t   steps_r;
  cnt_t   occ_r;
  key_t   ext_key;

  assign ext_key = key_t'($signed(in_key));

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_key_r  <= mem_key[idx_r];
      rd_dist_r <= mem_dist[idx_r];
    end
    if (cmd.put || cmd.fill) begin
      mem_key[idx_r]  <= car_key_r;
      mem_dist[idx_r] <= car_dist_r;
    end else if (cmd.shift) begin
      mem_key[prev_r]  <= rd_key_r;
      mem_dist[prev_r] <= rd_dist_r - idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      occ_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (cmd.rd) rd_valid_r <= valid_r[idx_r];
      if (cmd.fill) valid_r[idx_r] <= 1'b1;
      if (cmd.clear) valid_r[prev_r] <= 1'b0;
      if (cmd.occ_inc) occ_r <= occ_r + cnt_t'(1);
      else if (cmd.occ_dec) occ_r <= occ_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      car_key_r  <= ext_key;
      car_dist_r <= '0;
      idx_r      <= in_hash[IDX_W-1:0];
      home_r     <= in_hash[IDX_W-1:0];
      steps_r    <= '0;
    end else if (cmd.rewind) begin
      car_dist_r <= '0;
      idx_r      <= home_r;
      steps_r    <= '0;
    end else begin
      if (cmd.put) car_key_r <= rd_key_r;
      if (cmd.to_found) begin
        idx_r   <= found_r + idx_t'(1);
        prev_r  <= found_r;
        // the removed bucket counts as visited
        steps_r <= cnt_t'(1);
      end else if (cmd.step) begin
        prev_r  <= idx_r;
        idx_r   <= idx_r + idx_t'(1);
        steps_r <= steps_r + cnt_t'(1);
        if (!cmd.put) car_dist_r <= car_dist_r + idx_t'(1);
        else          car_dist_r <= rd_dist_r + idx_t'(1);
      end
      if (cmd.rd && !cmd.step) found_r <= idx_r;
    end
  end

  always_comb begin
    sts.valid     = rd_valid_r;
    sts.key_eq    = (rd_key_r == car_key_r);
    sts.dist_gt   = (car_dist_r > rd_dist_r);
    sts.dist_zero = (rd_dist_r == '0);
    sts.last      = (steps_r == cnt_t'(NUM_BUCKETS));
    sts.full      = (occ_r >= cnt_t'(NUM_BUCKETS));
  end

`ifndef ASSERT_OFF
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= cnt_t'(NUM_BUCKETS))
    else $error("occupancy over capacity");
  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.occ_inc |-> occ_r < cnt_t'(NUM_BUCKETS))
    else $error("insert into full table");
  a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.occ_dec |-> occ_r != '0)
    else $error("remove from empty table");
`endif
endmodule

// ----- src/rhh_ctrl.sv -----
// ----------------------------------------------------------------------------
// rhh_ctrl: operation sequencer
// Find pass, then insert placement or backward-shift removal; result register.
// ----------------------------------------------------------------------------
module rhh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_kind,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output rhh_pkg::rhh_cmd_t cmd,
  input  rhh_pkg::rhh_sts_t sts
);
  import rhh_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FRD    = 9'b000000010,
    S_FCHK   = 9'b000000100,
    S_PRLD   = 9'b000001000,
    S_PRD    = 9'b000010000,
    S_PCHK   = 9'b000100000,
    S_RRD    = 9'b001000000,
    S_RCHK   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] kind_r;
  logic       found_r, found_nxt;
  logic [1:0] status_r, status_nxt;
  logic       out_valid_r;
  logic       hit_r, hit_nxt;

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, status_r, found_r};

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    hit_nxt    = hit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load  = 1'b1;
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (!sts.valid || sts.last || (!sts.key_eq && sts.dist_gt)) begin
          hit_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (sts.key_eq) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_FRD;
        end
        if (state_nxt == S_DONE) begin
          if (kind_r == OP_INSERT) begin
            found_nxt = hit_nxt;
            if (hit_nxt) begin
              status_nxt = ST_DUP;
            end else if (sts.full) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_DONE;
              state_nxt  = S_PRLD;
            end
          end else if (kind_r == OP_REMOVE) begin
            found_nxt  = hit_nxt;
            status_nxt = hit_nxt ? ST_DONE : ST_ABSENT;
            if (hit_nxt) begin
              cmd.to_found = 1'b1;
              cmd.occ_dec  = 1'b1;
              state_nxt    = S_RRD;
            end
          end else begin
            found_nxt  = hit_nxt;
            status_nxt = hit_nxt ? ST_DONE : ST_ABSENT;
          end
        end
      end
      S_PRLD: begin
        cmd.rewind = 1'b1;
        state_nxt  = S_PRD;
      end
      S_PRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (!sts.valid) begin
          cmd.fill    = 1'b1;
          cmd.occ_inc = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.put  = sts.dist_gt;
          cmd.step = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_RRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        if (!sts.valid || sts.dist_zero || sts.last) begin
          cmd.clear = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.shift = 1'b1;
          cmd.step  = 1'b1;
          state_nxt = S_RRD;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) kind_r <= in_kind;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
  end

`ifndef ASSERT_OFF
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.put || cmd.fill, cmd.shift}) <= 1)
    else $error("two memory writes in one cycle");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !out_valid_r)
    else $error("result overwritten");
  a_idle_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(cmd.fill || cmd.put || cmd.shift || cmd.clear))
    else $error("table write while idle");
`endif
endmodule

// ----- src/robin_hood_hash_table.sv -----
// ----------------------------------------------------------------------------
// robin_hood_hash_table: Robin Hood hash table with backward-shift deletion
// Insert, lookup and remove of keys over an open-addressed bucket memory.
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)              tuser
// in_      in   key[31:0], hash_value[63:32]            kind[1:0]
// out_     out  found[0], status[2:1], zeros[7:3]       -
//
// One item at a time. Each probe is a registered memory read followed by a
// compare; an item runs a find pass and then, for insert or remove, a
// placement pass or a backward-shift pass.
// Reset clears all valid bits and the occupancy count at once.
// A new item is taken only after the previous result has been taken.
// ----------------------------------------------------------------------------
module robin_hood_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key, hash_value
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // found, status
);
  import rhh_pkg::*;

  rhh_cmd_t cmd;
  rhh_sts_t sts;

  rhh_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_kind(in_tuser),
    .out_tvalid, .out_tready, .out_tdata, .cmd, .sts
  );

  rhh_datapath u_dp (
    .clk, .rst_n, .cmd,
    .in_key(in_tdata[31:0]), .in_hash(in_tdata[63:32]), .sts
  );
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the Robin Hood hash table
// Drives insert, lookup and remove items over the input stream and checks
// each result against a bucket-level model of the table kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import rhh_pkg::*;

  localparam int MAX_CYCLES = 2_000_000;
  localparam int N_RANDOM   = 2000;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } reply_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] hash;
    logic        has_exp;
    logic        exp_found;
    logic [1:0]  exp_status;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  key_t tbl_key  [NUM_BUCKETS];
  logic tbl_vld  [NUM_BUCKETS];
  idx_t tbl_dist [NUM_BUCKETS];
  int   tbl_occ;

  reply_t pending_q[$];
  int     errors = 0;
  int     cycles = 0;
  bit     quiet = 1'b0;
  bit     hold_off = 1'b0;

  // recently used keys, so lookups/removes hit often
  logic [31:0] used_key[$];
  logic [31:0] used_hash[$];

  always #2 clk = ~clk;

  robin_hood_hash_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic bit table_find(key_t k, idx_t home, output idx_t where);
    idx_t i;
    int   d;
    i = home;
    d = 0;
    where = '0;
    for (int n = 0; n < NUM_BUCKETS; n++) begin
      if (!tbl_vld[i]) return 1'b0;
      if (tbl_key[i] == k) begin
        where = i;
        return 1'b1;
      end
      if (d > int'(tbl_dist[i])) return 1'b0;
      d++;
      i = i + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void table_place(key_t k, idx_t home);
    idx_t i;
    idx_t d;
    key_t tk;
    idx_t td;
    i = home;
    d = '0;
    for (int n = 0; n < NUM_BUCKETS; n++) begin
      if (!tbl_vld[i]) begin
        tbl_vld[i] = 1'b1;
        tbl_key[i] = k;
        tbl_dist[i] = d;
        tbl_occ++;
        return;
      end
      if (d > tbl_dist[i]) begin
        tk = tbl_key[i];
        td = tbl_dist[i];
        tbl_key[i] = k;
        tbl_dist[i] = d;
        k = tk;
        d = td;
      end
      d = d + 1'b1;
      i = i + 1'b1;
    end
  endfunction

  function automatic void table_erase(idx_t pos);
    idx_t j;
    idx_t nx;
    j = pos;
    for (int n = 0; n + 1 < NUM_BUCKETS; n++) begin
      nx = j + 1'b1;
      if (!tbl_vld[nx] || tbl_dist[nx] == 0) break;
      tbl_key[j] = tbl_key[nx];
      tbl_dist[j] = tbl_dist[nx] - 1'b1;
      j = nx;
    end
    tbl_vld[j] = 1'b0;
    if (tbl_occ > 0) tbl_occ--;
  endfunction

  function automatic reply_t table_apply(logic [1:0] kind, key_t k, logic [31:0] hash);
    reply_t r;
    idx_t   home;
    idx_t   pos;
    bit     hit;
    home = hash[IDX_W-1:0];
    hit = table_find(k, home, pos);
    r.found = 1'b0;
    r.status = ST_DONE;
    if (kind == OP_INSERT) begin
      if (hit) begin
        r.found = 1'b1;
        r.status = ST_DUP;
      end else if (tbl_occ >= NUM_BUCKETS) begin
        r.status = ST_FULL;
      end else begin
        table_place(k, home);
      end
    end else if (kind == OP_REMOVE) begin
      if (hit) begin
        r.found = 1'b1;
        table_erase(pos);
      end else begin
        r.status = ST_ABSENT;
      end
    end else begin
      r.found = hit;
      r.status = hit ? ST_DONE : ST_ABSENT;
    end
    return r;
  endfunction

  task automatic send_item(logic [1:0] kind, logic [31:0] key, logic [31:0] hash,
                           bit has_exp, logic exp_found, logic [1:0] exp_status);
    reply_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {hash, key};
    in_tuser <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = table_apply(kind, key, hash);
    if (has_exp && (r.found !== exp_found || r.status !== exp_status)) begin
      $error("table row: predicted found=%0d status=%0d, typed found=%0d status=%0d",
             r.found, r.status, exp_found, exp_status);
      errors++;
    end
    pending_q.push_back(r);
    if (kind == OP_INSERT && used_key.size() < 200) begin
      used_key.push_back(key);
      used_hash.push_back(hash);
    end
    @(negedge clk);
  endtask

  // receiver
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 1'b0;
      else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk);
      end else out_tready <= 1'b1;
    end
  end

  // long stall of the receiver, once
  initial begin
    @(posedge rst_n);
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    reply_t e;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_tdata[0] !== e.found) begin
          $error("found: expected %0d, actual %0d", e.found, out_tdata[0]);
          errors++;
        end
        if (out_tdata[2:1] !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_tdata[2:1]);
          errors++;
        end
      end
    end
  end

  initial begin
    @(posedge clk);
    while (cycles < MAX_CYCLES) @(posedge clk);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    row_t        rows[$];
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] hash;
    int          pick;
    int          waitc;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      tbl_vld[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_dist[i] = '0;
    end
    tbl_occ = 0;
    rows = '{
      '{OP_LOOKUP, 32'h0000_0000, 32'h0, 1, 1'b0, ST_ABSENT},
      '{OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, ST_ABSENT},
      '{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, ST_DONE},
      '{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, ST_DUP},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, ST_DONE},
      '{OP_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, ST_DONE},
      '{OP_INSERT, 32'h8000_0000, 32'h0000_003F, 0, 1'b0, ST_DONE},
      '{OP_INSERT, 32'h7FFF_FFFF, 32'h0000_003E, 0, 1'b0, ST_DONE},
      '{OP_INSERT, 32'h0000_0000, 32'h0000_003F, 0, 1'b0, ST_DONE},
      '{OP_LOOKUP, 32'h8000_0000, 32'h0000_003F, 0, 1'b0, ST_DONE},
      '{OP_LOOKUP, 32'h1234_5678, 32'h0000_003F, 1, 1'b0, ST_ABSENT},
      '{OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, ST_DONE},
      '{OP_LOOKUP, 32'h0000_0000, 32'h0000_003F, 0, 1'b0, ST_DONE},
      '{OP_REMOVE, 32'h8000_0000, 32'h0000_003F, 1, 1'b1, ST_DONE},
      '{OP_REMOVE, 32'h8000_0000, 32'h0000_003F, 1, 1'b0, ST_ABSENT},
      '{OP_REMOVE, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 0, 1'b0, ST_DONE},
      '{OP_REMOVE, 32'h0000_0000, 32'h5555_5555, 0, 1'b0, ST_DONE}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (rows[i])
      send_item(rows[i].kind, rows[i].key, rows[i].hash,
                rows[i].has_exp, rows[i].exp_found, rows[i].exp_status);
    // fill the table to capacity in one cluster, then overflow, then drain
    for (int i = 0; i < NUM_BUCKETS + 2; i++)
      send_item(OP_INSERT, $urandom, 32'($urandom_range(0, 3)) << 1,
                0, 1'b0, ST_DONE);
    send_item(OP_INSERT, 32'hDEAD_BEEF, 32'h0, 1, 1'b0, ST_FULL);
    while (used_key.size() > 0) begin
      send_item(OP_REMOVE, used_key.pop_front(), used_hash.pop_front(), 0, 1'b0, ST_DONE);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM * 9 / 10) quiet = 1'b1;
      pick = $urandom_range(0, 9);
      hash = $urandom;
      if (n % 400 < 200) hash[5:0] = 6'($urandom_range(0, 7));
      key = $urandom;
      if (pick < 5) kind = OP_INSERT;
      else if (pick < 8) kind = OP_LOOKUP;
      else if (pick < 9) kind = OP_REMOVE;
      else kind = 2'($urandom_range(1, 3));
      if (kind != OP_INSERT && used_key.size() > 0 && $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, used_key.size() - 1);
        key = used_key[pick];
        hash = used_hash[pick];
        if (kind == OP_REMOVE) begin
          used_key.delete(pick);
          used_hash.delete(pick);
        end
      end
      if (used_key.size() >= 150) begin
        used_key.delete(0);
        used_hash.delete(0);
      end
      send_item(kind, key, hash, 0, 1'b0, ST_DONE);
    end
    in_tvalid <= 1'b0;
    waitc = 0;
    while (pending_q.size() > 0 && waitc < 100000) begin
      @(posedge clk);
      waitc++;
    end
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
